FILE: hw/rtl/dqc_pkg.sv
// ----------------------------------------------------------------------------
// dqc_pkg
// Shared types, codes and slot arithmetic for the deque with cursor.
// ----------------------------------------------------------------------------
package dqc_pkg;

  // ring geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned KIND_W = 4;
  localparam int unsigned STAT_W = 2;

  // op queue between front and back, depth a power of two
  localparam int unsigned OPQ_DEPTH = 2;
  localparam int unsigned OPQ_PTR_W = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
  localparam int unsigned OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

  // input kind codes
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 4'd1;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_HEAD       = 4'd4;
  localparam logic [KIND_W-1:0] KIND_TAIL       = 4'd5;
  localparam logic [KIND_W-1:0] KIND_NEXT       = 4'd6;
  localparam logic [KIND_W-1:0] KIND_PREV       = 4'd7;
  localparam logic [KIND_W-1:0] KIND_READ       = 4'd8;
  localparam logic [KIND_W-1:0] KIND_DUMP_UP    = 4'd9;
  localparam logic [KIND_W-1:0] KIND_DUMP_DOWN  = 4'd10;

  // status codes
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  // decoded operation
  typedef enum logic [3:0] {
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_HEAD,
    OP_TAIL,
    OP_NEXT,
    OP_PREV,
    OP_READ,
    OP_DUMP_UP,
    OP_DUMP_DOWN,
    OP_BAD
  } op_code_e;

  typedef struct packed {
    op_code_e                  code;
    logic signed [DATA_W-1:0]  value;
  } op_t;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // next slot around the ring
  function automatic slot_t slot_inc(input slot_t s);
    slot_t r;
    if (s == SLOT_W'(DEPTH - 1)) r = '0;
    else                          r = s + SLOT_W'(1);
    return r;
  endfunction

  // previous slot around the ring
  function automatic slot_t slot_dec(input slot_t s);
    slot_t r;
    if (s == '0) r = SLOT_W'(DEPTH - 1);
    else         r = s - SLOT_W'(1);
    return r;
  endfunction

  // slot plus a count of at most DEPTH, wrapped
  function automatic slot_t slot_add(input slot_t s, input cnt_t n);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(s) + SUM_W'(n);
    if (sum >= SUM_W'(DEPTH)) sum = sum - SUM_W'(DEPTH);
    return sum[SLOT_W-1:0];
  endfunction

  // distance of a slot from the head, wrapped
  function automatic cnt_t slot_offset(input slot_t s, input slot_t h);
    logic [SUM_W-1:0] d;
    if (s >= h) d = SUM_W'(s) - SUM_W'(h);
    else        d = SUM_W'(s) + SUM_W'(DEPTH) - SUM_W'(h);
    return d[CNT_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/dqc_front.sv
// ----------------------------------------------------------------------------
// dqc_front
// Accepts input beats, decodes the kind into an operation and holds it in a
// short queue until the back end takes it.
// ----------------------------------------------------------------------------
module dqc_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push,
  output logic                                   full,
  input  logic [dqc_pkg::KIND_W-1:0]             kind_i,
  input  logic signed [dqc_pkg::DATA_W-1:0]      value_i,
  output logic                                   op_valid_o,
  output dqc_pkg::op_t                           op_o,
  input  logic                                   op_pop_i
);

  dqc_pkg::op_t                     fq_q [dqc_pkg::OPQ_DEPTH];
  logic [dqc_pkg::OPQ_PTR_W-1:0]    wptr_q, wptr_d;
  logic [dqc_pkg::OPQ_PTR_W-1:0]    rptr_q, rptr_d;
  logic [dqc_pkg::OPQ_CNT_W-1:0]    cnt_q, cnt_d;
  logic                             wr_en, rd_en;
  dqc_pkg::op_t                     op_dec;

  // kind decode
  always_comb begin
    op_dec.value = value_i;
    unique case (kind_i)
      dqc_pkg::KIND_PUSH_BACK:  op_dec.code = dqc_pkg::OP_PUSH_BACK;
      dqc_pkg::KIND_PUSH_FRONT: op_dec.code = dqc_pkg::OP_PUSH_FRONT;
      dqc_pkg::KIND_POP_BACK:   op_dec.code = dqc_pkg::OP_POP_BACK;
      dqc_pkg::KIND_POP_FRONT:  op_dec.code = dqc_pkg::OP_POP_FRONT;
      dqc_pkg::KIND_HEAD:       op_dec.code = dqc_pkg::OP_HEAD;
      dqc_pkg::KIND_TAIL:       op_dec.code = dqc_pkg::OP_TAIL;
      dqc_pkg::KIND_NEXT:       op_dec.code = dqc_pkg::OP_NEXT;
      dqc_pkg::KIND_PREV:       op_dec.code = dqc_pkg::OP_PREV;
      dqc_pkg::KIND_READ:       op_dec.code = dqc_pkg::OP_READ;
      dqc_pkg::KIND_DUMP_UP:    op_dec.code = dqc_pkg::OP_DUMP_UP;
      dqc_pkg::KIND_DUMP_DOWN:  op_dec.code = dqc_pkg::OP_DUMP_DOWN;
      default:                  op_dec.code = dqc_pkg::OP_BAD;
    endcase
  end

  // queue handshakes
  assign full       = (cnt_q == dqc_pkg::OPQ_CNT_W'(dqc_pkg::OPQ_DEPTH));
  assign op_valid_o = (cnt_q != '0);
  assign op_o       = fq_q[rptr_q];
  assign wr_en      = push && !full;
  assign rd_en      = op_pop_i && op_valid_o;

  // pointer and fill update
  always_comb begin
    wptr_d = wr_en ? wptr_q + dqc_pkg::OPQ_PTR_W'(1) : wptr_q;
    rptr_d = rd_en ? rptr_q + dqc_pkg::OPQ_PTR_W'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (wr_en && !rd_en) cnt_d = cnt_q + dqc_pkg::OPQ_CNT_W'(1);
    if (rd_en && !wr_en) cnt_d = cnt_q - dqc_pkg::OPQ_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) fq_q[wptr_q] <= op_dec;
  end

endmodule

FILE: hw/rtl/dqc_back.sv
// ----------------------------------------------------------------------------
// dqc_back
// Executes decoded operations against the ring store, keeps head, count and
// cursor, streams dumps and holds one result beat for the consumer.
// ----------------------------------------------------------------------------
module dqc_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   op_valid_i,
  input  dqc_pkg::op_t                           op_i,
  output logic                                   op_pop_o,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [dqc_pkg::DATA_W-1:0]      data_o,
  output logic [dqc_pkg::STAT_W-1:0]             status_o,
  output logic                                   cursor_valid_o,
  output logic [dqc_pkg::CNT_W-1:0]              entry_count_o,
  output logic                                   last_o
);

  typedef enum logic [2:0] {
    ST_EXEC = 3'b001,
    ST_READ = 3'b010,
    ST_DUMP = 3'b100
  } bk_state_e;

  bk_state_e                        state_q, state_d;
  dqc_pkg::slot_t                   head_q, head_d;
  dqc_pkg::cnt_t                    count_q, count_d;
  dqc_pkg::slot_t                   cur_q, cur_d;
  logic                             live_q, live_d;
  dqc_pkg::slot_t                   ptr_q, ptr_d;
  dqc_pkg::cnt_t                    left_q, left_d;
  logic                             down_q, down_d;

  logic signed [dqc_pkg::DATA_W-1:0] mem_q [dqc_pkg::DEPTH];
  logic signed [dqc_pkg::DATA_W-1:0] rd_data_q;
  logic                             mem_we;
  dqc_pkg::slot_t                   mem_waddr;
  logic                             rd_en;
  dqc_pkg::slot_t                   rd_addr;

  logic                             res_valid_q;
  logic signed [dqc_pkg::DATA_W-1:0] res_data_q;
  logic [dqc_pkg::STAT_W-1:0]       res_status_q;
  logic                             res_cvalid_q;
  dqc_pkg::cnt_t                    res_count_q;
  logic                             res_last_q;

  logic                             res_free;
  logic                             res_load;
  logic signed [dqc_pkg::DATA_W-1:0] res_data;
  logic [dqc_pkg::STAT_W-1:0]       res_status;
  logic                             res_last;

  dqc_pkg::slot_t                   tail_slot;
  dqc_pkg::slot_t                   back_slot;
  dqc_pkg::slot_t                   victim;
  dqc_pkg::cnt_t                    cur_off;
  logic                             is_empty;
  logic                             is_full;

  assign res_free  = !res_valid_q || pop;
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == dqc_pkg::CNT_W'(dqc_pkg::DEPTH));
  assign tail_slot = dqc_pkg::slot_add(head_q, count_q - dqc_pkg::CNT_W'(1));
  assign back_slot = dqc_pkg::slot_add(head_q, count_q);
  assign cur_off   = dqc_pkg::slot_offset(cur_q, head_q);

  // operation sequencer
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    cur_d      = cur_q;
    live_d     = live_q;
    ptr_d      = ptr_q;
    left_d     = left_q;
    down_d     = down_q;
    op_pop_o   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = head_q;
    rd_en      = 1'b0;
    rd_addr    = cur_q;
    res_load   = 1'b0;
    res_data   = '0;
    res_status = dqc_pkg::STATUS_OK;
    res_last   = 1'b1;
    victim     = head_q;

    unique case (state_q)
      ST_EXEC: begin
        if (op_valid_i && res_free) begin
          op_pop_o = 1'b1;
          res_load = 1'b1;
          unique case (op_i.code)
            dqc_pkg::OP_PUSH_BACK, dqc_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                res_status = dqc_pkg::STATUS_FULL;
              end else if (is_empty) begin
                mem_we    = 1'b1;
                mem_waddr = head_q;
                count_d   = dqc_pkg::CNT_W'(1);
              end else if (op_i.code == dqc_pkg::OP_PUSH_BACK) begin
                mem_we    = 1'b1;
                mem_waddr = back_slot;
                count_d   = count_q + dqc_pkg::CNT_W'(1);
              end else begin
                head_d    = dqc_pkg::slot_dec(head_q);
                mem_we    = 1'b1;
                mem_waddr = dqc_pkg::slot_dec(head_q);
                count_d   = count_q + dqc_pkg::CNT_W'(1);
              end
            end
            dqc_pkg::OP_POP_BACK, dqc_pkg::OP_POP_FRONT: begin
              if (is_empty) begin
                res_status = dqc_pkg::STATUS_EMPTY;
              end else begin
                victim = (op_i.code == dqc_pkg::OP_POP_BACK) ? tail_slot : head_q;
                if (live_q && cur_q == victim) live_d = 1'b0;
                if (op_i.code == dqc_pkg::OP_POP_FRONT) head_d = dqc_pkg::slot_inc(head_q);
                count_d = count_q - dqc_pkg::CNT_W'(1);
              end
            end
            dqc_pkg::OP_HEAD, dqc_pkg::OP_TAIL: begin
              if (is_empty) begin
                live_d     = 1'b0;
                res_status = dqc_pkg::STATUS_EMPTY;
              end else begin
                cur_d  = (op_i.code == dqc_pkg::OP_HEAD) ? head_q : tail_slot;
                live_d = 1'b1;
              end
            end
            dqc_pkg::OP_NEXT, dqc_pkg::OP_PREV: begin
              if (!live_q || is_empty) begin
                live_d     = 1'b0;
                res_status = dqc_pkg::STATUS_EMPTY;
              end else if (op_i.code == dqc_pkg::OP_NEXT) begin
                if ({1'b0, cur_off} + dqc_pkg::SUM_W'(1) >= {1'b0, count_q}) live_d = 1'b0;
                else cur_d = dqc_pkg::slot_inc(cur_q);
              end else begin
                if (cur_off == '0) live_d = 1'b0;
                else cur_d = dqc_pkg::slot_dec(cur_q);
              end
            end
            dqc_pkg::OP_READ: begin
              if (live_q && !is_empty) begin
                res_load = 1'b0;
                rd_en    = 1'b1;
                rd_addr  = cur_q;
                state_d  = ST_READ;
              end else begin
                res_status = dqc_pkg::STATUS_EMPTY;
              end
            end
            dqc_pkg::OP_DUMP_UP, dqc_pkg::OP_DUMP_DOWN: begin
              if (is_empty) begin
                live_d     = 1'b0;
                res_status = dqc_pkg::STATUS_EMPTY;
              end else begin
                res_load = 1'b0;
                down_d   = (op_i.code == dqc_pkg::OP_DUMP_DOWN);
                cur_d    = (op_i.code == dqc_pkg::OP_DUMP_UP) ? head_q : tail_slot;
                live_d   = 1'b1;
                ptr_d    = (op_i.code == dqc_pkg::OP_DUMP_UP) ? head_q : tail_slot;
                left_d   = count_q;
                rd_en    = 1'b1;
                rd_addr  = ptr_d;
                state_d  = ST_DUMP;
              end
            end
            default: begin
              res_status = dqc_pkg::STATUS_EMPTY;
            end
          endcase
        end
      end
      ST_READ: begin
        if (res_free) begin
          res_load = 1'b1;
          res_data = rd_data_q;
          state_d  = ST_EXEC;
        end
      end
      ST_DUMP: begin
        if (res_free) begin
          res_load = 1'b1;
          res_data = rd_data_q;
          res_last = (left_q == dqc_pkg::CNT_W'(1));
          left_d   = left_q - dqc_pkg::CNT_W'(1);
          if (res_last) begin
            state_d = ST_EXEC;
          end else begin
            ptr_d   = down_q ? dqc_pkg::slot_dec(ptr_q) : dqc_pkg::slot_inc(ptr_q);
            rd_en   = 1'b1;
            rd_addr = ptr_d;
          end
        end
      end
      default: begin
        state_d = ST_EXEC;
      end
    endcase
  end

  // control and pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_EXEC;
      head_q      <= '0;
      count_q     <= '0;
      cur_q       <= '0;
      live_q      <= 1'b0;
      ptr_q       <= '0;
      left_q      <= '0;
      down_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      cur_q   <= cur_d;
      live_q  <= live_d;
      ptr_q   <= ptr_d;
      left_q  <= left_d;
      down_q  <= down_d;
      if (res_load)  res_valid_q <= 1'b1;
      else if (pop)  res_valid_q <= 1'b0;
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_data_q   <= res_data;
      res_status_q <= res_status;
      res_cvalid_q <= live_d;
      res_count_q  <= count_d;
      res_last_q   <= res_last;
    end
  end

  // ring store with registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= op_i.value;
    if (rd_en)  rd_data_q <= mem_q[rd_addr];
  end

  assign empty          = !res_valid_q;
  assign data_o         = res_data_q;
  assign status_o       = res_status_q;
  assign cursor_valid_o = res_cvalid_q;
  assign entry_count_o  = res_count_q;
  assign last_o         = res_last_q;

endmodule

FILE: hw/rtl/double_ended_queue_with_cursor.sv
// A push, pop or cursor move is registered into the op queue, executed, and registered into
// the result beat; a read and each dump beat also pass through the registered store read port.
// Throughput: one operation per cycle while results are popped, set by the execute unit;
// a read holds it for the execute and read states, a dump for a setup step plus one beat per held entry.
// Reset (async, active low) empties the deque, clears the cursor and both queues; store
// contents are kept and never read unwritten.
// ----------------------------------------------------------------------------
// double_ended_queue_with_cursor
// Bounded deque of signed 32-bit values in a ring, with a cursor, reads and
// ordered dumps. A decode front end feeds an execute back end through a queue.
// ----------------------------------------------------------------------------
module double_ended_queue_with_cursor (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push,
  output logic                                   full,
  input  logic [dqc_pkg::KIND_W-1:0]             kind_i,
  input  logic signed [dqc_pkg::DATA_W-1:0]      value_i,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [dqc_pkg::DATA_W-1:0]      data_o,
  output logic [dqc_pkg::STAT_W-1:0]             status_o,
  output logic                                   cursor_valid_o,
  output logic [dqc_pkg::CNT_W-1:0]              entry_count_o,
  output logic                                   last_o
);

  logic          op_valid;
  dqc_pkg::op_t  op;
  logic          op_pop;

  // decode and op queue
  dqc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  // execute, store and result beat
  dqc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (op_valid),
    .op_i           (op),
    .op_pop_o       (op_pop),
    .empty          (empty),
    .pop            (pop),
    .data_o         (data_o),
    .status_o       (status_o),
    .cursor_valid_o (cursor_valid_o),
    .entry_count_o  (entry_count_o),
    .last_o         (last_o)
  );

endmodule

FILE: sim/tb_double_ended_queue_with_cursor.sv
// ----------------------------------------------------------------------------
// tb_double_ended_queue_with_cursor
// Self-checking bench for the deque with cursor. A directed table opens with
// the empty and cursor corner cases. Random episodes follow: fills, drains,
// cursor walks, dumps and noise. Every returned beat is checked field by field
// against a behavioral copy of the deque kept here.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_with_cursor;

  // unused kind codes
  localparam logic [dqc_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 4'd11;
  localparam logic [dqc_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 4'd15;

  localparam int unsigned RANDOM_ITEMS = 305;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_START   = 150;
  localparam int unsigned HOLD_CYCLES  = 100;

  // one result beat as seen on the output ports
  typedef struct packed {
    logic signed [dqc_pkg::DATA_W-1:0] data;
    logic [dqc_pkg::STAT_W-1:0]        status;
    logic                              cursor_valid;
    dqc_pkg::cnt_t                     entry_count;
    logic                              is_last;
  } beat_t;

  // one row of the directed table
  typedef struct packed {
    logic [dqc_pkg::KIND_W-1:0]        kind;
    logic signed [dqc_pkg::DATA_W-1:0] value;
    logic                              typed;
    logic signed [dqc_pkg::DATA_W-1:0] data;
    logic [dqc_pkg::STAT_W-1:0]        status;
    logic                              cursor_valid;
    dqc_pkg::cnt_t                     entry_count;
  } op_row_t;

  logic                              clk_i   = 1'b0;
  logic                              rst_ni  = 1'b0;
  logic                              push    = 1'b0;
  logic                              full;
  logic [dqc_pkg::KIND_W-1:0]        kind_i  = '0;
  logic signed [dqc_pkg::DATA_W-1:0] value_i = '0;
  logic                              empty;
  logic                              pop     = 1'b0;
  logic signed [dqc_pkg::DATA_W-1:0] data_o;
  logic [dqc_pkg::STAT_W-1:0]        status_o;
  logic                              cursor_valid_o;
  dqc_pkg::cnt_t                     entry_count_o;
  logic                              last_o;

  // shadow deque state
  logic signed [dqc_pkg::DATA_W-1:0] ring [dqc_pkg::DEPTH];
  dqc_pkg::slot_t                    head_pos;
  dqc_pkg::cnt_t                     held;
  dqc_pkg::slot_t                    cursor_pos;
  logic                              cursor_on;

  beat_t       expected_beats[$];
  int unsigned items_sent;
  int unsigned mismatches;
  int unsigned rx_cycles;
  int unsigned hold_left;
  int unsigned stall_cycles;

  // directed corner cases, expected beat typed where obvious
  op_row_t directed_ops [25] = '{
    '{dqc_pkg::KIND_POP_BACK,   32'sd0, 1'b1, 32'sd0, dqc_pkg::STATUS_EMPTY, 1'b0, 5'd0},
    '{dqc_pkg::KIND_POP_FRONT,  32'sd0, 1'b1, 32'sd0, dqc_pkg::STATUS_EMPTY, 1'b0, 5'd0},
    '{dqc_pkg::KIND_HEAD,       32'sd0, 1'b1, 32'sd0, dqc_pkg::STATUS_EMPTY, 1'b0, 5'd0},
    '{dqc_pkg::KIND_TAIL,       32'sd0, 1'b1, 32'sd0, dqc_pkg::STATUS_EMPTY, 1'b0, 5'd0},
    '{dqc_pkg::KIND_NEXT,       32'sd0, 1'b1, 32'sd0, dqc_pkg::STATUS_EMPTY, 1'b0, 5'd0},
    '{dqc_pkg::KIND_PREV,       32'sd0, 1'b1, 32'sd0, dqc_pkg::STATUS_EMPTY, 1'b0, 5'd0},
    '{dqc_pkg::KIND_READ,       32'sd0, 1'b1, 32'sd0, dqc_pkg::STATUS_EMPTY, 1'b0, 5'd0},
    '{dqc_pkg::KIND_DUMP_UP,    32'sd0, 1'b1, 32'sd0, dqc_pkg::STATUS_EMPTY, 1'b0, 5'd0},
    '{dqc_pkg::KIND_DUMP_DOWN,  32'sd0, 1'b1, 32'sd0, dqc_pkg::STATUS_EMPTY, 1'b0, 5'd0},
    '{KIND_SPARE_FIRST,         -32'sd1, 1'b1, 32'sd0, dqc_pkg::STATUS_EMPTY, 1'b0, 5'd0},
    '{KIND_SPARE_LAST,          -32'sd1, 1'b1, 32'sd0, dqc_pkg::STATUS_EMPTY, 1'b0, 5'd0},
    '{dqc_pkg::KIND_PUSH_FRONT, 32'sh7fffffff, 1'b1, 32'sd0, dqc_pkg::STATUS_OK, 1'b0, 5'd1},
    '{dqc_pkg::KIND_PUSH_BACK,  32'sh80000000, 1'b1, 32'sd0, dqc_pkg::STATUS_OK, 1'b0, 5'd2},
    '{dqc_pkg::KIND_PUSH_FRONT, -32'sd1, 1'b0, 32'sd0, dqc_pkg::STATUS_OK, 1'b0, 5'd0},
    '{dqc_pkg::KIND_PUSH_BACK,  32'sd0, 1'b0, 32'sd0, dqc_pkg::STATUS_OK, 1'b0, 5'd0},
    '{dqc_pkg::KIND_HEAD,       32'sd0, 1'b0, 32'sd0, dqc_pkg::STATUS_OK, 1'b0, 5'd0},
    '{dqc_pkg::KIND_READ,       32'sd0, 1'b0, 32'sd0, dqc_pkg::STATUS_OK, 1'b0, 5'd0},
    '{dqc_pkg::KIND_PREV,       32'sd0, 1'b0, 32'sd0, dqc_pkg::STATUS_OK, 1'b0, 5'd0},
    '{dqc_pkg::KIND_TAIL,       32'sd0, 1'b0, 32'sd0, dqc_pkg::STATUS_OK, 1'b0, 5'd0},
    '{dqc_pkg::KIND_NEXT,       32'sd0, 1'b0, 32'sd0, dqc_pkg::STATUS_OK, 1'b0, 5'd0},
    '{dqc_pkg::KIND_TAIL,       32'sd0, 1'b0, 32'sd0, dqc_pkg::STATUS_OK, 1'b0, 5'd0},
    '{dqc_pkg::KIND_POP_BACK,   32'sd0, 1'b0, 32'sd0, dqc_pkg::STATUS_OK, 1'b0, 5'd0},
    '{dqc_pkg::KIND_DUMP_DOWN,  32'sd0, 1'b0, 32'sd0, dqc_pkg::STATUS_OK, 1'b0, 5'd0},
    '{dqc_pkg::KIND_NEXT,       32'sd0, 1'b0, 32'sd0, dqc_pkg::STATUS_OK, 1'b0, 5'd0},
    '{dqc_pkg::KIND_DUMP_UP,    32'sd0, 1'b0, 32'sd0, dqc_pkg::STATUS_OK, 1'b0, 5'd0}
  };

  double_ended_queue_with_cursor dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .empty          (empty),
    .pop            (pop),
    .data_o         (data_o),
    .status_o       (status_o),
    .cursor_valid_o (cursor_valid_o),
    .entry_count_o  (entry_count_o),
    .last_o         (last_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ring position, wrapped
  function automatic dqc_pkg::slot_t ring_slot(input int unsigned s);
    return dqc_pkg::slot_t'(s % dqc_pkg::DEPTH);
  endfunction

  // queue one expected beat, cursor and count as they stand after the op
  function automatic void expect_beat(input logic signed [dqc_pkg::DATA_W-1:0] d,
                                      input logic [dqc_pkg::STAT_W-1:0] s,
                                      input logic l);
    beat_t b;
    b.data         = d;
    b.status       = s;
    b.cursor_valid = cursor_on;
    b.entry_count  = held;
    b.is_last      = l;
    expected_beats.push_back(b);
  endfunction

  // apply one operation to the shadow deque and queue its beats
  function automatic void deque_apply(input logic [dqc_pkg::KIND_W-1:0] k,
                                      input logic signed [dqc_pkg::DATA_W-1:0] v);
    logic [dqc_pkg::STAT_W-1:0]        st;
    logic signed [dqc_pkg::DATA_W-1:0] rd;
    dqc_pkg::slot_t                    tail_pos;
    dqc_pkg::slot_t                    victim;
    dqc_pkg::slot_t                    offset;
    st       = dqc_pkg::STATUS_OK;
    rd       = '0;
    tail_pos = ring_slot(head_pos + held + dqc_pkg::DEPTH - 1);
    offset   = ring_slot(cursor_pos + dqc_pkg::DEPTH - head_pos);
    case (k)
      dqc_pkg::KIND_PUSH_BACK, dqc_pkg::KIND_PUSH_FRONT: begin
        if (held >= dqc_pkg::DEPTH) begin
          st = dqc_pkg::STATUS_FULL;
        end else if (held == 0) begin
          ring[head_pos] = v;
          held = dqc_pkg::cnt_t'(1);
        end else if (k == dqc_pkg::KIND_PUSH_BACK) begin
          ring[ring_slot(head_pos + held)] = v;
          held = held + dqc_pkg::cnt_t'(1);
        end else begin
          head_pos = ring_slot(head_pos + dqc_pkg::DEPTH - 1);
          ring[head_pos] = v;
          held = held + dqc_pkg::cnt_t'(1);
        end
      end
      dqc_pkg::KIND_POP_BACK, dqc_pkg::KIND_POP_FRONT: begin
        if (held == 0) begin
          st = dqc_pkg::STATUS_EMPTY;
        end else begin
          victim = (k == dqc_pkg::KIND_POP_BACK) ? tail_pos : head_pos;
          if (cursor_on && cursor_pos == victim) cursor_on = 1'b0;
          if (k == dqc_pkg::KIND_POP_FRONT) head_pos = ring_slot(head_pos + 1);
          held = held - dqc_pkg::cnt_t'(1);
        end
      end
      dqc_pkg::KIND_HEAD, dqc_pkg::KIND_TAIL: begin
        if (held == 0) begin
          cursor_on = 1'b0;
          st = dqc_pkg::STATUS_EMPTY;
        end else begin
          cursor_pos = (k == dqc_pkg::KIND_HEAD) ? head_pos : tail_pos;
          cursor_on  = 1'b1;
        end
      end
      dqc_pkg::KIND_NEXT, dqc_pkg::KIND_PREV: begin
        if (!cursor_on || held == 0) begin
          cursor_on = 1'b0;
          st = dqc_pkg::STATUS_EMPTY;
        end else if (k == dqc_pkg::KIND_NEXT) begin
          // stepping past the tail drops the cursor
          if (offset + 1 >= held) cursor_on = 1'b0;
          else                    cursor_pos = ring_slot(cursor_pos + 1);
        end else begin
          if (offset == 0) cursor_on = 1'b0;
          else             cursor_pos = ring_slot(cursor_pos + dqc_pkg::DEPTH - 1);
        end
      end
      dqc_pkg::KIND_READ: begin
        if (cursor_on && held != 0) rd = ring[cursor_pos];
        else                        st = dqc_pkg::STATUS_EMPTY;
      end
      dqc_pkg::KIND_DUMP_UP, dqc_pkg::KIND_DUMP_DOWN: begin
        if (held == 0) begin
          cursor_on = 1'b0;
          expect_beat('0, dqc_pkg::STATUS_EMPTY, 1'b1);
          return;
        end
        cursor_pos = (k == dqc_pkg::KIND_DUMP_UP) ? head_pos : tail_pos;
        cursor_on  = 1'b1;
        for (int unsigned i = 0; i < held; i++) begin
          if (k == dqc_pkg::KIND_DUMP_UP) rd = ring[ring_slot(head_pos + i)];
          else rd = ring[ring_slot(tail_pos + dqc_pkg::DEPTH - i)];
          expect_beat(rd, dqc_pkg::STATUS_OK, i + 1 == held);
        end
        return;
      end
      default: begin
        st = dqc_pkg::STATUS_EMPTY;
      end
    endcase
    expect_beat(rd, st, 1'b1);
  endfunction

  // push value, extremes now and then
  function automatic logic signed [dqc_pkg::DATA_W-1:0] pick_value();
    logic signed [dqc_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'sh7fffffff;
      1:       v = 32'sh80000000;
      2:       v = 32'sd0;
      3:       v = -32'sd1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // offer one op, random gaps outside the steady window, predict on accept
  task automatic send_op(input logic [dqc_pkg::KIND_W-1:0] k,
                         input logic signed [dqc_pkg::DATA_W-1:0] v);
    if (!(items_sent >= 150 && items_sent < 210)) begin
      while ($urandom_range(0, 99) < 35) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push    <= 1'b1;
    kind_i  <= k;
    value_i <= v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    deque_apply(k, v);
    items_sent++;
  endtask

  // stimulus
  initial begin
    int unsigned                episode;
    int unsigned                n;
    logic                       upward;
    logic [dqc_pkg::KIND_W-1:0] k;
    head_pos       = '0;
    held           = '0;
    cursor_pos     = '0;
    cursor_on      = 1'b0;
    items_sent     = 0;
    episode        = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_ops[i]) begin
      send_op(directed_ops[i].kind, directed_ops[i].value);
      if (directed_ops[i].typed) begin
        void'(expected_beats.pop_back());
        expected_beats.push_back('{directed_ops[i].data, directed_ops[i].status,
                                   directed_ops[i].cursor_valid,
                                   directed_ops[i].entry_count, 1'b1});
      end
    end

    // random episodes, the first one overfills the deque
    while (items_sent < $size(directed_ops) + RANDOM_ITEMS) begin
      case ((episode == 0) ? 0 : $urandom_range(0, 9))
        0, 1: begin
          n = (episode == 0) ? dqc_pkg::DEPTH + 2 : $urandom_range(4, dqc_pkg::DEPTH + 4);
          repeat (n) begin
            k = $urandom_range(0, 1) ? dqc_pkg::KIND_PUSH_BACK : dqc_pkg::KIND_PUSH_FRONT;
            send_op(k, pick_value());
          end
        end
        2: begin
          // park the cursor on the end about to be popped
          upward = ($urandom_range(0, 1) != 0);
          if ($urandom_range(0, 1)) begin
            send_op(upward ? dqc_pkg::KIND_HEAD : dqc_pkg::KIND_TAIL, pick_value());
          end
          repeat ($urandom_range(3, dqc_pkg::DEPTH + 2)) begin
            send_op(upward ? dqc_pkg::KIND_POP_FRONT : dqc_pkg::KIND_POP_BACK, pick_value());
            if ($urandom_range(0, 5) == 0) upward = !upward;
          end
        end
        3, 4, 5: begin
          upward = ($urandom_range(0, 1) != 0);
          send_op(upward ? dqc_pkg::KIND_HEAD : dqc_pkg::KIND_TAIL, pick_value());
          repeat ($urandom_range(1, dqc_pkg::DEPTH + 2)) begin
            if ($urandom_range(0, 3) == 0) begin
              send_op(dqc_pkg::KIND_READ, pick_value());
            end else begin
              if ($urandom_range(0, 5) == 0) upward = !upward;
              send_op(upward ? dqc_pkg::KIND_NEXT : dqc_pkg::KIND_PREV, pick_value());
            end
          end
        end
        6: begin
          k = $urandom_range(0, 1) ? dqc_pkg::KIND_DUMP_UP : dqc_pkg::KIND_DUMP_DOWN;
          send_op(k, pick_value());
          send_op(dqc_pkg::KIND_READ, pick_value());
        end
        default: begin
          repeat ($urandom_range(1, 6)) begin
            send_op(dqc_pkg::KIND_W'($urandom_range(0, 15)), pick_value());
          end
        end
      endcase
      episode++;
    end
    push <= 1'b0;

    // wait for every expected beat, then let the pipe settle
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // result side: check each beat, random stalls, one long hold-off
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni) begin
      rx_cycles <= rx_cycles + 1;
      if (pop && !empty) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: data %0d status %0d", data_o, status_o);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (data_o !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, data_o);
            mismatches++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatches++;
          end
          if (cursor_valid_o !== want.cursor_valid) begin
            $error("cursor_valid: expected %0d, got %0d", want.cursor_valid,
                   cursor_valid_o);
            mismatches++;
          end
          if (entry_count_o !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   entry_count_o);
            mismatches++;
          end
          if (last_o !== want.is_last) begin
            $error("last: expected %0d, got %0d", want.is_last, last_o);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else if (rx_cycles == HOLD_START) begin
        hold_left <= HOLD_CYCLES;
        pop <= 1'b0;
      end else if (rx_cycles >= 600 && rx_cycles < 800) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 99) >= 35);
      end
    end
  end

  initial begin
    mismatches   = 0;
    rx_cycles    = 0;
    hold_left    = 0;
    stall_cycles = 0;
  end

  // watchdog on cycles with no beat taken on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

FILE: filelist.f
hw/rtl/dqc_pkg.sv
hw/rtl/dqc_front.sv
hw/rtl/dqc_back.sv
hw/rtl/double_ended_queue_with_cursor.sv
sim/tb_double_ended_queue_with_cursor.sv
